[sv/wav_hdr_pkg.sv]
// Shared types and constants for the WAVE header parser.
`timescale 1ns / 1ps

package wav_hdr_pkg;

	// Four-character tags as they appear when read as little-endian words.
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_FACT = 32'h7463_6166;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	// Only a 16-byte format chunk is accepted; a fact chunk carries one word.
	localparam logic [31:0] FMT_SIZE  = 32'd16;
	localparam logic [31:0] FACT_SIZE = 32'd4;

	// Divider geometry: data size over block align.
	localparam int DIV_N_W = 32;
	localparam int DIV_D_W = 16;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_NOT_RIFF   = 3'd1,
		ST_NOT_WAVE   = 3'd2,
		ST_BAD_FMT    = 3'd3,
		ST_ZERO_ALIGN = 3'd4
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    clear;      // restart: parse phase back to RIFF, chunk and format state to zero
		logic    shift;      // shift the byte into the word assembler
		logic    load_tag;   // latch the chunk tag
		logic    load_skip;  // load the skip counter from the assembled size
		logic    fmt_skip;   // load the skip counter with the format size
		logic    dec_skip;   // count one payload byte
		logic    store_fmt;  // store the byte into the format fields
		logic    load_fact;  // latch the fact frame count
		logic    emit_err;   // produce an error result
		status_t err_code;
		logic    emit_data;  // produce the data result
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic word_full;
		logic w_riff;
		logic w_wave;
		logic w_fmt_size;
		logic w_fact_size;
		logic w_zero;
		logic tag_fmt;
		logic tag_fact;
		logic tag_data;
		logic skip_last;
		logic div_busy;
		logic out_valid;
	} dp_stat_t;

endpackage

[sv/wav_hdr_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module wav_hdr_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [wav_hdr_pkg::DIV_N_W-1:0] dividend,
	input  logic [wav_hdr_pkg::DIV_D_W-1:0] divisor,
	output logic                          busy,
	output logic                          done,
	output logic [wav_hdr_pkg::DIV_N_W-1:0] quotient
);
	import wav_hdr_pkg::*;

	localparam int CNT_W = $clog2(DIV_N_W);

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DIV_N_W-1:0] quo_q;
	logic [DIV_D_W:0]   rem_q;
	logic [DIV_D_W-1:0] den_q;
	logic [DIV_D_W:0]   rem_shift;
	logic               ge;

	// One trial subtraction per step.
	always_comb begin
		rem_shift = {rem_q[DIV_D_W-1:0], quo_q[DIV_N_W-1]};
		ge        = (rem_shift >= {1'b0, den_q});
	end

	// Control: step counter and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIV_N_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Operands: the quotient register shifts the dividend out as quotient bits come in.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_N_W-2:0], ge};
			rem_q <= ge ? (rem_shift - {1'b0, den_q}) : rem_shift;
		end
	end

	assign busy     = busy_q;
	assign done     = busy_q && (cnt_q == '0);
	assign quotient = {quo_q[DIV_N_W-2:0], ge};

endmodule

[sv/wav_hdr_ctrl.sv]
// Parse-phase state machine of the WAVE header parser.
`timescale 1ns / 1ps

module wav_hdr_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   operation,
	input  wav_hdr_pkg::dp_stat_t  stat,
	output logic                   in_stall,
	output wav_hdr_pkg::ctrl_cmd_t cmd
);
	import wav_hdr_pkg::*;

	typedef enum logic [8:0] {
		PH_RIFF  = 9'b0_0000_0001,
		PH_RSIZE = 9'b0_0000_0010,
		PH_WAVE  = 9'b0_0000_0100,
		PH_CTAG  = 9'b0_0000_1000,
		PH_CSIZE = 9'b0_0001_0000,
		PH_FMT   = 9'b0_0010_0000,
		PH_FACT  = 9'b0_0100_0000,
		PH_SKIP  = 9'b0_1000_0000,
		PH_DONE  = 9'b1_0000_0000
	} phase_t;

	phase_t phase_q;
	phase_t phase_d;
	logic   in_fire;

	// Hold the input during a division, and while a result waits unless parsing is over.
	assign in_stall = stat.div_busy || (stat.out_valid && (phase_q != PH_DONE));
	assign in_fire  = in_valid && !in_stall;

	// Next phase and datapath commands for the accepted beat.
	always_comb begin
		phase_d = phase_q;
		cmd     = '0;
		cmd.err_code = ST_OK;
		if (in_fire) begin
			if (operation) begin
				cmd.clear = 1'b1;
				phase_d   = PH_RIFF;
			end else begin
				unique case (phase_q)
					PH_FMT: begin
						cmd.store_fmt = 1'b1;
						cmd.dec_skip  = 1'b1;
						if (stat.skip_last) begin
							phase_d = PH_CTAG;
						end
					end
					PH_SKIP: begin
						cmd.dec_skip = 1'b1;
						if (stat.skip_last) begin
							phase_d = PH_CTAG;
						end
					end
					PH_DONE: begin
						phase_d = PH_DONE;
					end
					PH_RIFF: begin
						cmd.shift = 1'b1;
						if (stat.word_full) begin
							if (stat.w_riff) begin
								phase_d = PH_RSIZE;
							end else begin
								cmd.emit_err = 1'b1;
								cmd.err_code = ST_NOT_RIFF;
								phase_d      = PH_DONE;
							end
						end
					end
					PH_RSIZE: begin
						cmd.shift = 1'b1;
						if (stat.word_full) begin
							phase_d = PH_WAVE;
						end
					end
					PH_WAVE: begin
						cmd.shift = 1'b1;
						if (stat.word_full) begin
							if (stat.w_wave) begin
								phase_d = PH_CTAG;
							end else begin
								cmd.emit_err = 1'b1;
								cmd.err_code = ST_NOT_WAVE;
								phase_d      = PH_DONE;
							end
						end
					end
					PH_CTAG: begin
						cmd.shift = 1'b1;
						if (stat.word_full) begin
							cmd.load_tag = 1'b1;
							phase_d      = PH_CSIZE;
						end
					end
					PH_CSIZE: begin
						cmd.shift = 1'b1;
						if (stat.word_full) begin
							if (stat.tag_fmt) begin
								if (stat.w_fmt_size) begin
									cmd.fmt_skip = 1'b1;
									phase_d      = PH_FMT;
								end else begin
									cmd.emit_err = 1'b1;
									cmd.err_code = ST_BAD_FMT;
									phase_d      = PH_DONE;
								end
							end else if (stat.tag_fact && stat.w_fact_size) begin
								phase_d = PH_FACT;
							end else if (stat.tag_data) begin
								cmd.emit_data = 1'b1;
								phase_d       = PH_DONE;
							end else if (stat.w_zero) begin
								phase_d = PH_CTAG;
							end else begin
								cmd.load_skip = 1'b1;
								phase_d       = PH_SKIP;
							end
						end
					end
					PH_FACT: begin
						cmd.shift = 1'b1;
						if (stat.word_full) begin
							cmd.load_fact = 1'b1;
							phase_d       = PH_CTAG;
						end
					end
					default: begin
						phase_d = PH_RIFF;
					end
				endcase
			end
		end
	end

	// Phase register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF;
		end else begin
			phase_q <= phase_d;
		end
	end

endmodule

[sv/wav_hdr_dp.sv]
// Datapath: word assembly, captured format fields, skip counter and result register.
`timescale 1ns / 1ps

module wav_hdr_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [7:0]             data_byte,
	input  wav_hdr_pkg::ctrl_cmd_t cmd,
	input  logic                   out_stall,
	output wav_hdr_pkg::dp_stat_t  stat,
	output logic                   out_valid,
	output logic [2:0]             status,
	output logic [15:0]            format_tag,
	output logic [15:0]            channel_count,
	output logic [31:0]            sample_rate,
	output logic [31:0]            byte_rate,
	output logic [15:0]            block_align,
	output logic [15:0]            bits_per_sample,
	output logic [31:0]            data_size,
	output logic [31:0]            frame_count
);
	import wav_hdr_pkg::*;

	logic [31:0] asm_q;
	logic [1:0]  idx_q;
	logic [31:0] ctag_q;
	logic [31:0] skip_q;
	logic [15:0] cap_tag_q;
	logic [15:0] cap_chan_q;
	logic [31:0] cap_rate_q;
	logic [31:0] cap_brate_q;
	logic [15:0] cap_align_q;
	logic [15:0] cap_bits_q;
	logic [31:0] fact_q;

	logic        out_valid_q;
	status_t     status_q;
	logic [15:0] o_tag_q;
	logic [15:0] o_chan_q;
	logic [31:0] o_rate_q;
	logic [31:0] o_brate_q;
	logic [15:0] o_align_q;
	logic [15:0] o_bits_q;
	logic [31:0] o_size_q;
	logic [31:0] o_frames_q;

	logic [31:0] word;
	logic [3:0]  fmt_pos;
	logic        div_start;
	logic        div_busy;
	logic        div_done;
	logic [31:0] div_quo;
	logic        emit_now;

	// The word completed by this byte, little-endian.
	assign word    = {data_byte, asm_q[31:8]};
	assign fmt_pos = 4'(FMT_SIZE[4:0] - skip_q[4:0]);

	// A data result needs the divider only without a fact count and with a nonzero align.
	assign div_start = cmd.emit_data && (fact_q == '0) && (cap_align_q != '0);
	assign emit_now  = cmd.emit_err || (cmd.emit_data && !div_start);

	// Status towards the controller.
	always_comb begin
		stat             = '0;
		stat.word_full   = (idx_q == 2'd3);
		stat.w_riff      = (word == TAG_RIFF);
		stat.w_wave      = (word == TAG_WAVE);
		stat.w_fmt_size  = (word == FMT_SIZE);
		stat.w_fact_size = (word == FACT_SIZE);
		stat.w_zero      = (word == '0);
		stat.tag_fmt     = (ctag_q == TAG_FMT);
		stat.tag_fact    = (ctag_q == TAG_FACT);
		stat.tag_data    = (ctag_q == TAG_DATA);
		stat.skip_last   = (skip_q == 32'd1);
		stat.div_busy    = div_busy;
		stat.out_valid   = out_valid_q;
	end

	// Word assembler and chunk bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			asm_q  <= '0;
			idx_q  <= '0;
			ctag_q <= '0;
			skip_q <= '0;
			fact_q <= '0;
		end else if (cmd.clear) begin
			asm_q  <= '0;
			idx_q  <= '0;
			ctag_q <= '0;
			skip_q <= '0;
			fact_q <= '0;
		end else begin
			if (cmd.shift) begin
				asm_q <= word;
				idx_q <= idx_q + 2'd1;
			end
			if (cmd.load_tag) begin
				ctag_q <= word;
			end
			if (cmd.load_skip) begin
				skip_q <= word;
			end else if (cmd.fmt_skip) begin
				skip_q <= FMT_SIZE;
			end else if (cmd.dec_skip) begin
				skip_q <= skip_q - 32'd1;
			end
			if (cmd.load_fact) begin
				fact_q <= word;
			end
		end
	end

	// Format chunk fields, filled one byte at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_tag_q   <= '0;
			cap_chan_q  <= '0;
			cap_rate_q  <= '0;
			cap_brate_q <= '0;
			cap_align_q <= '0;
			cap_bits_q  <= '0;
		end else if (cmd.clear) begin
			cap_tag_q   <= '0;
			cap_chan_q  <= '0;
			cap_rate_q  <= '0;
			cap_brate_q <= '0;
			cap_align_q <= '0;
			cap_bits_q  <= '0;
		end else if (cmd.store_fmt) begin
			case (fmt_pos)
				4'd0:  cap_tag_q[7:0]     <= data_byte;
				4'd1:  cap_tag_q[15:8]    <= data_byte;
				4'd2:  cap_chan_q[7:0]    <= data_byte;
				4'd3:  cap_chan_q[15:8]   <= data_byte;
				4'd4:  cap_rate_q[7:0]    <= data_byte;
				4'd5:  cap_rate_q[15:8]   <= data_byte;
				4'd6:  cap_rate_q[23:16]  <= data_byte;
				4'd7:  cap_rate_q[31:24]  <= data_byte;
				4'd8:  cap_brate_q[7:0]   <= data_byte;
				4'd9:  cap_brate_q[15:8]  <= data_byte;
				4'd10: cap_brate_q[23:16] <= data_byte;
				4'd11: cap_brate_q[31:24] <= data_byte;
				4'd12: cap_align_q[7:0]   <= data_byte;
				4'd13: cap_align_q[15:8]  <= data_byte;
				4'd14: cap_bits_q[7:0]    <= data_byte;
				default: cap_bits_q[15:8] <= data_byte;
			endcase
		end
	end

	// Frame count division.
	wav_hdr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (word),
		.divisor  (cap_align_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Result valid flag: set on a new result, cleared when the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_now || div_done) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (cmd.emit_err) begin
			status_q   <= cmd.err_code;
			o_tag_q    <= '0;
			o_chan_q   <= '0;
			o_rate_q   <= '0;
			o_brate_q  <= '0;
			o_align_q  <= '0;
			o_bits_q   <= '0;
			o_size_q   <= '0;
			o_frames_q <= '0;
		end else if (cmd.emit_data) begin
			o_tag_q   <= cap_tag_q;
			o_chan_q  <= cap_chan_q;
			o_rate_q  <= cap_rate_q;
			o_brate_q <= cap_brate_q;
			o_align_q <= cap_align_q;
			o_bits_q  <= cap_bits_q;
			o_size_q  <= word;
			if (fact_q != '0) begin
				status_q   <= ST_OK;
				o_frames_q <= fact_q;
			end else if (cap_align_q == '0) begin
				status_q   <= ST_ZERO_ALIGN;
				o_frames_q <= '0;
			end else begin
				status_q <= ST_OK;
			end
		end else if (div_done) begin
			o_frames_q <= div_quo;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign format_tag      = o_tag_q;
	assign channel_count   = o_chan_q;
	assign sample_rate     = o_rate_q;
	assign byte_rate       = o_brate_q;
	assign block_align     = o_align_q;
	assign bits_per_sample = o_bits_q;
	assign data_size       = o_size_q;
	assign frame_count     = o_frames_q;

endmodule

[sv/wav_header_parser.sv]
// Result: out_valid rises in the cycle after the last byte of the data chunk size when the
// frame count comes from a fact chunk or block align is zero; otherwise it waits for the divider.
// Throughput: one byte per cycle; the input stalls while the 32-step bit-serial
// frame-count divider runs, and while a result is held unless the parser has finished the file.
// Reset: asynchronous, active low; the parser returns to expecting the RIFF tag with all
// captured fields zero and no result pending.
`timescale 1ns / 1ps

module wav_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] format_tag,
	output logic [15:0] channel_count,
	output logic [31:0] sample_rate,
	output logic [31:0] byte_rate,
	output logic [15:0] block_align,
	output logic [15:0] bits_per_sample,
	output logic [31:0] data_size,
	output logic [31:0] frame_count
);
	import wav_hdr_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// Phase controller.
	wav_hdr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.stat      (stat),
		.in_stall  (in_stall),
		.cmd       (cmd)
	);

	// Datapath with result register.
	wav_hdr_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.data_byte       (data_byte),
		.cmd             (cmd),
		.out_stall       (out_stall),
		.stat            (stat),
		.out_valid       (out_valid),
		.status          (status),
		.format_tag      (format_tag),
		.channel_count   (channel_count),
		.sample_rate     (sample_rate),
		.byte_rate       (byte_rate),
		.block_align     (block_align),
		.bits_per_sample (bits_per_sample),
		.data_size       (data_size),
		.frame_count     (frame_count)
	);

endmodule

[test/wav_header_checker.sv]
// Checker that predicts the parser's header summaries and compares them with the output beats.
`timescale 1ns / 1ps

module wav_header_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        operation,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	input  logic [15:0] format_tag,
	input  logic [15:0] channel_count,
	input  logic [31:0] sample_rate,
	input  logic [31:0] byte_rate,
	input  logic [15:0] block_align,
	input  logic [15:0] bits_per_sample,
	input  logic [31:0] data_size,
	input  logic [31:0] frame_count,
	output int          fails,
	output int          pending
);
	import wav_hdr_pkg::*;

	typedef enum logic [3:0] {
		PH_RIFF, PH_RSIZE, PH_WAVE, PH_CTAG, PH_CSIZE, PH_FMT, PH_FACT, PH_SKIP, PH_DONE
	} phase_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] format_tag;
		logic [15:0] channel_count;
		logic [31:0] sample_rate;
		logic [31:0] byte_rate;
		logic [15:0] block_align;
		logic [15:0] bits_per_sample;
		logic [31:0] data_size;
		logic [31:0] frame_count;
	} wav_summary_t;

	// Shadow copy of the parser state.
	phase_t      phase;
	logic [2:0]  byte_idx;
	logic [31:0] word_acc;
	logic [31:0] chunk_tag;
	logic [31:0] skip_left;
	logic [15:0] fmt_tag;
	logic [15:0] fmt_channels;
	logic [31:0] fmt_rate;
	logic [31:0] fmt_byte_rate;
	logic [15:0] fmt_align;
	logic [15:0] fmt_bits;
	logic [31:0] fact_count;

	wav_summary_t summary_q[$];
	int           mismatches;

	task automatic clear_parser();
		phase         = PH_RIFF;
		byte_idx      = '0;
		word_acc      = '0;
		chunk_tag     = '0;
		skip_left     = '0;
		fmt_tag       = '0;
		fmt_channels  = '0;
		fmt_rate      = '0;
		fmt_byte_rate = '0;
		fmt_align     = '0;
		fmt_bits      = '0;
		fact_count    = '0;
	endtask

	// Skip a chunk payload by its size; an empty payload goes straight to the next header.
	task automatic begin_skip(input logic [31:0] size);
		if (size == 0) begin
			phase = PH_CTAG;
		end else begin
			skip_left = size;
			phase     = PH_SKIP;
		end
	endtask

	// Advance the shadow parser by one accepted beat and form any summary it completes.
	task automatic parse_beat(input logic op, input logic [7:0] b,
			output bit emitted, output wav_summary_t res);
		logic [31:0] w;
		logic [3:0]  pos;
		bit          full;
		emitted = 0;
		res     = '0;
		if (op) begin
			clear_parser();
			return;
		end

		// Format payload bytes land in their little-endian lanes.
		if (phase == PH_FMT) begin
			pos = 4'(FMT_SIZE - skip_left);
			if (pos < 2)
				fmt_tag[{pos[0], 3'b000} +: 8] = b;
			else if (pos < 4)
				fmt_channels[{pos[0], 3'b000} +: 8] = b;
			else if (pos < 8)
				fmt_rate[{pos[1:0], 3'b000} +: 8] = b;
			else if (pos < 12)
				fmt_byte_rate[{pos[1:0], 3'b000} +: 8] = b;
			else if (pos < 14)
				fmt_align[{pos[0], 3'b000} +: 8] = b;
			else
				fmt_bits[{pos[0], 3'b000} +: 8] = b;
			skip_left--;
			if (skip_left == 0)
				phase = PH_CTAG;
			return;
		end
		if (phase == PH_SKIP) begin
			skip_left--;
			if (skip_left == 0)
				phase = PH_CTAG;
			return;
		end
		if (phase == PH_DONE)
			return;

		// Gather four bytes into one word, least significant first.
		word_acc = {b, word_acc[31:8]};
		full     = (byte_idx >= 3);
		byte_idx = full ? 3'd0 : byte_idx + 3'd1;
		if (!full)
			return;
		w = word_acc;

		case (phase)
			PH_RIFF: begin
				if (w != TAG_RIFF) begin
					emitted    = 1;
					res.status = ST_NOT_RIFF;
					phase      = PH_DONE;
				end else begin
					phase = PH_RSIZE;
				end
			end
			PH_RSIZE: phase = PH_WAVE;
			PH_WAVE: begin
				if (w != TAG_WAVE) begin
					emitted    = 1;
					res.status = ST_NOT_WAVE;
					phase      = PH_DONE;
				end else begin
					phase = PH_CTAG;
				end
			end
			PH_CTAG: begin
				chunk_tag = w;
				phase     = PH_CSIZE;
			end
			PH_CSIZE: begin
				if (chunk_tag == TAG_FMT) begin
					if (w != FMT_SIZE) begin
						emitted    = 1;
						res.status = ST_BAD_FMT;
						phase      = PH_DONE;
					end else begin
						skip_left = FMT_SIZE;
						phase     = PH_FMT;
					end
				end else if (chunk_tag == TAG_FACT) begin
					if (w == FACT_SIZE)
						phase = PH_FACT;
					else
						begin_skip(w);
				end else if (chunk_tag == TAG_DATA) begin
					emitted             = 1;
					res.status          = ST_OK;
					res.format_tag      = fmt_tag;
					res.channel_count   = fmt_channels;
					res.sample_rate     = fmt_rate;
					res.byte_rate       = fmt_byte_rate;
					res.block_align     = fmt_align;
					res.bits_per_sample = fmt_bits;
					res.data_size       = w;
					if (fact_count != 0) begin
						res.frame_count = fact_count;
					end else if (fmt_align != 0) begin
						res.frame_count = w / fmt_align;
					end else begin
						res.frame_count = '0;
						res.status      = ST_ZERO_ALIGN;
					end
					phase = PH_DONE;
				end else begin
					begin_skip(w);
				end
			end
			PH_FACT: begin
				fact_count = w;
				phase      = PH_CTAG;
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
		end
	endtask

	// Track input beats through the shadow parser and match output beats in order.
	always @(posedge clk) begin : monitor
		wav_summary_t predicted;
		wav_summary_t observed;
		wav_summary_t oldest;
		bit           emitted;
		if (!arst_n) begin
			clear_parser();
			summary_q.delete();
		end else begin
			if (in_valid && !in_stall) begin
				parse_beat(operation, data_byte, emitted, predicted);
				if (emitted)
					summary_q.push_back(predicted);
			end
			if (out_valid && !out_stall) begin
				observed = {status, format_tag, channel_count, sample_rate, byte_rate,
					block_align, bits_per_sample, data_size, frame_count};
				if (summary_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: summary with none pending, status %0d", $realtime, status);
				end else begin
					oldest = summary_q.pop_front();
					check_field("status", 32'(oldest.status), 32'(observed.status));
					check_field("format_tag", 32'(oldest.format_tag), 32'(observed.format_tag));
					check_field("channel_count", 32'(oldest.channel_count),
						32'(observed.channel_count));
					check_field("sample_rate", oldest.sample_rate, observed.sample_rate);
					check_field("byte_rate", oldest.byte_rate, observed.byte_rate);
					check_field("block_align", 32'(oldest.block_align), 32'(observed.block_align));
					check_field("bits_per_sample", 32'(oldest.bits_per_sample),
						32'(observed.bits_per_sample));
					check_field("data_size", oldest.data_size, observed.data_size);
					check_field("frame_count", oldest.frame_count, observed.frame_count);
				end
			end
		end
		pending <= summary_q.size();
		fails   <= mismatches;
	end

endmodule

[test/wav_header_parser_tb.sv]
// Top level that streams WAVE file bytes into the header parser and reports the verdict.
`timescale 1ns / 1ps

module wav_header_parser_tb;
	import wav_hdr_pkg::*;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        operation = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [2:0]  status;
	logic [15:0] format_tag;
	logic [15:0] channel_count;
	logic [31:0] sample_rate;
	logic [31:0] byte_rate;
	logic [15:0] block_align;
	logic [15:0] bits_per_sample;
	logic [31:0] data_size;
	logic [31:0] frame_count;
	int          fails;
	int          pending;

	// Beats waiting to be sent: bit 8 is the restart flag, the rest the file byte.
	logic [8:0]  beat_q[$];
	int          useful_beats = 0;
	bit          idle_on = 1;

	wav_header_parser uut (.*);
	wav_header_checker summary_check (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the run hangs.
	initial begin
		#5000000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic push_byte(input logic [7:0] b, input bit counts);
		beat_q.push_back({1'b0, b});
		if (counts)
			useful_beats++;
	endtask

	task automatic push_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			push_byte(w[8 * i +: 8], 1);
	endtask

	task automatic push_restart();
		beat_q.push_back({1'b1, 8'($urandom)});
		useful_beats++;
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(1, 255);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_align();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom_range(1, 8));
			default: return 16'($urandom);
		endcase
	endfunction

	// A random tag that names none of the chunks the parser knows.
	function automatic logic [31:0] other_tag();
		logic [31:0] t;
		t = $urandom;
		while (t == TAG_FMT || t == TAG_FACT || t == TAG_DATA)
			t = $urandom;
		return t;
	endfunction

	task automatic push_file_head();
		push_word(TAG_RIFF);
		push_word(pick_word());
		push_word(TAG_WAVE);
	endtask

	task automatic push_fmt_chunk();
		push_word(TAG_FMT);
		push_word(FMT_SIZE);
		case ($urandom_range(0, 2))
			0: push_word({16'($urandom), 16'd1});
			1: push_word({16'($urandom), 16'd3});
			default: push_word($urandom);
		endcase
		push_word(pick_word());
		push_word(pick_word());
		push_word({16'($urandom), pick_align()});
	endtask

	// One of the chunks that may come before the data chunk.
	task automatic push_side_chunk();
		logic [31:0] size;
		case ($urandom_range(0, 3))
			0: push_fmt_chunk();
			1: begin
				push_word(TAG_FACT);
				push_word(FACT_SIZE);
				push_word(($urandom_range(0, 3) == 0) ? 32'h0 : pick_word());
			end
			2: begin
				size = $urandom_range(0, 7);
				if (size == FACT_SIZE)
					size = 5;
				push_word(TAG_FACT);
				push_word(size);
				repeat (size) push_byte(8'($urandom), 1);
			end
			default: begin
				size = $urandom_range(0, 7);
				push_word(other_tag());
				push_word(size);
				repeat (size) push_byte(8'($urandom), 1);
			end
		endcase
	endtask

	task automatic push_wave_file();
		push_file_head();
		if ($urandom_range(0, 9) != 0)
			push_fmt_chunk();
		repeat ($urandom_range(0, 4)) push_side_chunk();
		push_word(TAG_DATA);
		push_word(pick_word());
	endtask

	// Queue one file: mostly well formed, the rest broken, truncated or noise.
	task automatic build_file();
		logic [31:0] w;
		int          cut;
		push_restart();
		case ($urandom_range(0, 19))
			0: begin
				w = $urandom;
				if (w == TAG_RIFF)
					w ^= 32'h1;
				push_word(w);
			end
			1: begin
				push_word(TAG_RIFF);
				push_word(pick_word());
				w = $urandom;
				if (w == TAG_WAVE)
					w ^= 32'h100;
				push_word(w);
			end
			2: begin
				push_file_head();
				if ($urandom_range(0, 1))
					push_side_chunk();
				case ($urandom_range(0, 4))
					0: w = 32'd0;
					1: w = 32'd15;
					2: w = 32'd17;
					3: w = 32'hFFFF_FFFF;
					default: w = $urandom;
				endcase
				if (w == FMT_SIZE)
					w = 32'd18;
				push_word(TAG_FMT);
				push_word(w);
			end
			3: repeat ($urandom_range(1, 24)) push_byte(8'($urandom), 1);
			4: begin
				push_wave_file();
				cut = $urandom_range(1, beat_q.size() - 1);
				repeat (cut) void'(beat_q.pop_back());
			end
			default: push_wave_file();
		endcase
		// Bytes after the end of the header are simply ignored.
		repeat ($urandom_range(0, 4)) push_byte(8'($urandom), 0);
	endtask

	// Offer one beat, after an optional idle gap, and hold it until it is taken.
	task automatic send_beat(input logic [8:0] beat);
		int gap;
		gap = idle_on ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  = 1'b1;
		operation = beat[8];
		data_byte = beat[7:0];
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic drain_beats();
		while (beat_q.size() > 0)
			send_beat(beat_q.pop_front());
	endtask

	// Receiver: a random stall before each beat, and one long hold-off to back up the input.
	initial begin : receiver
		int hold;
		int taken;
		taken = 0;
		forever begin
			if (taken == 10)
				hold = 400;
			else if ($urandom_range(0, 3) == 0)
				hold = 0;
			else
				hold = $urandom_range(0, 10);
			if (hold > 0) begin
				out_stall = 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
			taken++;
		end
	end

	// Sender: reset, a few directed files, then random files, then drain and verdict.
	initial begin : sender
		int file_no;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Bad RIFF tag, then a good RIFF tag with a bad WAVE tag.
		push_byte("R", 1);
		push_byte("I", 1);
		push_byte("F", 1);
		push_byte(8'hFF, 1);
		beat_q.push_back({1'b1, 8'hFF});
		push_word(TAG_RIFF);
		push_word(32'h00FF_00FF);
		push_word(32'h4656_4157);
		beat_q.push_back({1'b1, 8'h00});
		push_byte(8'h00, 1);
		drain_beats();

		file_no = 0;
		while (useful_beats < 1700) begin
			idle_on = ($urandom_range(0, 3) != 0);
			build_file();
			drain_beats();
			file_no++;
			if (file_no == 15) begin
				in_valid = 1'b0;
				wait (pending == 0);
				@(negedge clk);
			end
		end
		in_valid = 1'b0;

		wait (pending == 0);
		repeat (40) @(negedge clk);
		if (fails == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
